// ===== rtl/sbmq_pkg.sv =====
package sbmq_pkg;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [2:0]         queue_id;
    logic signed [31:0] data_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    status_e            status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_TAKE,
    S_ENQ_LINK,
    S_DEQ_READ,
    S_DEQ_FREE,
    S_FAIL
  } state_e;

  typedef struct packed {
    logic load;
    logic enq_take;
    logic enq_commit;
    logic deq_commit;
    logic fail_commit;
  } cmd_t;

  typedef struct packed {
    logic acc_deq;
    logic acc_fail;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/shared_buffer_multi_queue.sv =====
// several fifo queues sharing one slot store, linked lists plus a free list
// input channel (in_valid_i/in_ready_o/in_item_i): enqueue or dequeue on one queue
// output channel (out_valid_o/out_ready_i/out_item_o): one result per input transfer
// enqueue: take then link step; dequeue: read then free step; result registered
// full, empty or bad queue number: result registered from the fail step
// one item in flight: a new item waits until the last one's steps are done,
// set by the read then write of the registered-read link and head/tail memories
// in_ready_o is high only while idle; the result register frees the block, so the
// next item is taken while a result still waits
// a stalled receiver holds the next result in its last step until out_ready_i
// reset: every queue empty, free list covers all slots in order; untouched slots
// are tracked by a fill count, so no clearing pass is needed and items are
// accepted as soon as reset ends
module shared_buffer_multi_queue #(
  parameter int SLOTS  = 256,
  parameter int QUEUES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sbmq_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sbmq_pkg::out_t out_item_o
);

  import sbmq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  sbmq_datapath #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_result_frees_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued without returning to idle");

  a_error_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |-> out_item_o.data_out == 32'sd0)
    else $error("failed operation returned nonzero data");

endmodule

// ===== rtl/sbmq_ram.sv =====
module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sbmq_ctrl.sv =====
module sbmq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  sbmq_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output sbmq_pkg::cmd_t cmd_o
);

  import sbmq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.acc_fail) begin
            state_d = S_FAIL;
          end else if (sts_i.acc_deq) begin
            state_d = S_DEQ_READ;
          end else begin
            state_d = S_ENQ_TAKE;
          end
        end
      end
      S_ENQ_TAKE: state_d = S_ENQ_LINK;
      S_DEQ_READ: state_d = S_DEQ_FREE;
      S_ENQ_LINK, S_DEQ_FREE, S_FAIL: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == S_IDLE);
    cmd_o             = '0;
    cmd_o.load        = (state_q == S_IDLE) && in_valid_i;
    cmd_o.enq_take    = (state_q == S_ENQ_TAKE);
    cmd_o.enq_commit  = (state_q == S_ENQ_LINK) && sts_i.out_free;
    cmd_o.deq_commit  = (state_q == S_DEQ_FREE) && sts_i.out_free;
    cmd_o.fail_commit = (state_q == S_FAIL) && sts_i.out_free;
  end

endmodule

// ===== rtl/sbmq_datapath.sv =====
module sbmq_datapath #(
  parameter int SLOTS  = 256,
  parameter int QUEUES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbmq_pkg::in_t  in_item_i,
  input  logic           out_ready_i,
  input  sbmq_pkg::cmd_t cmd_i,
  output sbmq_pkg::sts_t sts_o,
  output sbmq_pkg::out_t out_item_o,
  output logic           out_valid_o
);

  import sbmq_pkg::*;

  localparam int AW  = $clog2(SLOTS);
  localparam int PW  = $clog2(SLOTS + 1);
  localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QIW = (QW > 3) ? QW : 3;
  localparam logic [PW-1:0] NilPtr = PW'(SLOTS);

  func_e              func_q;
  logic [QW-1:0]      qidx_q;
  logic signed [31:0] din_q;
  logic [PW-1:0]      slot_q;
  logic [PW-1:0]      free_head_q, free_head_d;
  logic [PW-1:0]      fill_q, fill_d;
  logic [QUEUES-1:0]  nonempty_q, nonempty_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [QIW-1:0] in_qext;
  logic [QW-1:0]  in_qidx;
  logic [QW-1:0]  cur_qidx;
  logic           in_q_ok;
  logic           free_empty;
  logic           out_free;

  logic [PW-1:0]  head_rdata, tail_rdata, link_rdata;
  logic [31:0]    data_rdata;
  logic           head_we, link_we;
  logic [PW-1:0]  head_wdata, link_wdata;
  logic [PW-1:0]  link_waddr;
  logic [AW-1:0]  link_raddr;
  logic           next_null;

  assign in_qext    = QIW'(in_item_i.queue_id);
  assign in_qidx    = in_qext[QW-1:0];
  assign in_q_ok    = {29'd0, in_item_i.queue_id} < 32'(QUEUES);
  assign free_empty = free_head_q >= NilPtr;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cur_qidx   = cmd_i.load ? in_qidx : qidx_q;
  assign next_null  = link_rdata >= NilPtr;

  always_comb begin
    sts_o          = '0;
    sts_o.acc_deq  = (in_item_i.func == FUNC_DEQ);
    sts_o.acc_fail = !in_q_ok ||
                     ((in_item_i.func == FUNC_ENQ) ? free_empty : !nonempty_q[in_qidx]);
    sts_o.out_free = out_free;
  end

  // link store: take marks new tail, commit links old tail or recycles slot
  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_q;
    link_wdata = NilPtr;
    if (cmd_i.enq_take) begin
      link_we = 1'b1;
    end else if (cmd_i.enq_commit && nonempty_q[qidx_q]) begin
      link_we    = 1'b1;
      link_waddr = tail_rdata;
      link_wdata = slot_q;
    end else if (cmd_i.deq_commit) begin
      link_we    = 1'b1;
      link_waddr = head_rdata;
      link_wdata = free_head_q;
    end
  end

  always_comb begin
    head_we    = 1'b0;
    head_wdata = slot_q;
    if (cmd_i.enq_commit && !nonempty_q[qidx_q]) begin
      head_we = 1'b1;
    end else if (cmd_i.deq_commit && !next_null) begin
      head_we    = 1'b1;
      head_wdata = link_rdata;
    end
  end

  assign link_raddr = cmd_i.load ? free_head_q[AW-1:0] : head_rdata[AW-1:0];

  always_comb begin
    free_head_d = free_head_q;
    fill_d      = fill_q;
    nonempty_d  = nonempty_q;
    if (cmd_i.enq_take) begin
      // slots at or above the fill count were never linked; next free is the one above
      if (slot_q >= fill_q) begin
        free_head_d = slot_q + PW'(1);
      end else begin
        free_head_d = link_rdata;
      end
      if (slot_q == fill_q) begin
        fill_d = fill_q + PW'(1);
      end
    end
    if (cmd_i.enq_commit) begin
      nonempty_d[qidx_q] = 1'b1;
    end
    if (cmd_i.deq_commit) begin
      free_head_d = head_rdata;
      if (next_null) begin
        nonempty_d[qidx_q] = 1'b0;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.enq_commit) begin
      out_d       = '{data_out: '0, status: ST_OK};
      out_valid_d = 1'b1;
    end else if (cmd_i.deq_commit) begin
      out_d       = '{data_out: $signed(data_rdata), status: ST_OK};
      out_valid_d = 1'b1;
    end else if (cmd_i.fail_commit) begin
      out_d.data_out = '0;
      out_d.status   = (func_q == FUNC_DEQ) ? ST_EMPTY : ST_FULL;
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      fill_q      <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_item_i.func;
      qidx_q <= in_qidx;
      din_q  <= in_item_i.data_in;
      slot_q <= free_head_q;
    end
    out_q <= out_d;
  end

  sbmq_ram #(.WIDTH(PW), .DEPTH(QUEUES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (qidx_q),
    .wdata_i (head_wdata),
    .raddr_i (cur_qidx),
    .rdata_o (head_rdata)
  );

  sbmq_ram #(.WIDTH(PW), .DEPTH(QUEUES)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_commit),
    .waddr_i (qidx_q),
    .wdata_i (slot_q),
    .raddr_i (cur_qidx),
    .rdata_o (tail_rdata)
  );

  sbmq_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr[AW-1:0]),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  sbmq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_take),
    .waddr_i (slot_q[AW-1:0]),
    .wdata_i (din_q),
    .raddr_i (head_rdata[AW-1:0]),
    .rdata_o (data_rdata)
  );

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule
